/* design/quad_geofence_point_in_polygon_top_defines.svh */
// Assertion macros for the quadrilateral geofence block.
`ifndef QUAD_GEOFENCE_POINT_IN_POLYGON_TOP_DEFINES_SVH
`define QUAD_GEOFENCE_POINT_IN_POLYGON_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QGF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qgf: same-cycle check failed");
`define QGF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qgf: next-cycle check failed");
`else
`define QGF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define QGF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/qgf_pkg.sv */
// Shared constants and types for the quadrilateral geofence block.
package qgf_pkg;

   localparam int LatW       = 31;
   localparam int LonW       = 32;
   localparam int Corners    = 4;
   localparam int CountW     = 3;
   localparam int DiffW      = LonW + 1;
   localparam int ProdW      = 2 * DiffW;
   localparam int AddrW      = 5;
   localparam int DataW      = 32;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // 360 degrees in 1e-7 degree units
   localparam logic signed [DiffW-1:0] FullTurn = 33'sd3600000000;

   typedef logic signed [LatW-1:0] lat_type;
   typedef logic signed [LonW-1:0] lon_type;

   typedef enum logic [2:0] {
      REG_CORNER0_LAT = 3'd0,
      REG_CORNER0_LON = 3'd1,
      REG_CORNER1_LAT = 3'd2,
      REG_CORNER1_LON = 3'd3,
      REG_CORNER2_LAT = 3'd4,
      REG_CORNER2_LON = 3'd5,
      REG_CORNER3_LAT = 3'd6,
      REG_CORNER3_LON = 3'd7
   } csr_reg_type;

   typedef struct packed {
      lat_type [Corners-1:0] lat;
      lon_type [Corners-1:0] lon;
   } corners_type;

   // per-edge verdict, or the operands of the slope comparison
   typedef struct packed {
      logic                    decided;
      logic                    crossed;
      logic signed [DiffW-1:0] dy;
      logic [LonW-1:0]         dx;
      logic signed [DiffW-1:0] ey;
      logic [LonW-1:0]         ex;
   } edge_type;

   typedef struct packed {
      edge_type [Corners-1:0] edges;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* design/qgf_if.sv */
// Request and response channel interfaces.
interface qgf_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [30:0]   point_lat;
   logic signed [31:0]   point_lon;

   modport source (output valid, output point_lat, output point_lon, input ready);
   modport sink (input valid, input point_lat, input point_lon, output ready);
endinterface

interface qgf_rsp_if;
   logic       valid;
   logic       ready;
   logic       inside_res;
   logic [2:0] crossing_count;

   modport source (output valid, output inside_res, output crossing_count, input ready);
   modport sink (input valid, input inside_res, input crossing_count, output ready);
endinterface

/* design/qgf_csr.sv */
// Corner registers behind the APB-style configuration port.
module qgf_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [qgf_pkg::AddrW-1:0] paddr,
   input  logic [qgf_pkg::DataW-1:0] pwdata,
   output logic [qgf_pkg::DataW-1:0] prdata,
   output logic                      pready,
   output qgf_pkg::corners_type      corners
);
   import qgf_pkg::*;

   lat_type     lat_ff [Corners];
   lon_type     lon_ff [Corners];
   csr_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = csr_reg_type'(paddr[AddrW-1:2]);
   assign wr_en   = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Corners; k++) begin
            lat_ff[k] <= '0;
            lon_ff[k] <= '0;
         end
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_CORNER0_LAT: lat_ff[0] <= pwdata[LatW-1:0];
            REG_CORNER0_LON: lon_ff[0] <= pwdata[LonW-1:0];
            REG_CORNER1_LAT: lat_ff[1] <= pwdata[LatW-1:0];
            REG_CORNER1_LON: lon_ff[1] <= pwdata[LonW-1:0];
            REG_CORNER2_LAT: lat_ff[2] <= pwdata[LatW-1:0];
            REG_CORNER2_LON: lon_ff[2] <= pwdata[LonW-1:0];
            REG_CORNER3_LAT: lat_ff[3] <= pwdata[LatW-1:0];
            REG_CORNER3_LON: lon_ff[3] <= pwdata[LonW-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CORNER0_LAT: prdata = {lat_ff[0][LatW-1], lat_ff[0]};
         REG_CORNER0_LON: prdata = lon_ff[0];
         REG_CORNER1_LAT: prdata = {lat_ff[1][LatW-1], lat_ff[1]};
         REG_CORNER1_LON: prdata = lon_ff[1];
         REG_CORNER2_LAT: prdata = {lat_ff[2][LatW-1], lat_ff[2]};
         REG_CORNER2_LON: prdata = lon_ff[2];
         REG_CORNER3_LAT: prdata = {lat_ff[3][LatW-1], lat_ff[3]};
         REG_CORNER3_LON: prdata = lon_ff[3];
      endcase
   end

   always_comb begin
      for (int k = 0; k < Corners; k++) begin
         corners.lat[k] = lat_ff[k];
         corners.lon[k] = lon_ff[k];
      end
   end

endmodule

/* design/qgf_front.sv */
// Front end: accepts fixes and classifies each polygon edge.
module qgf_front (
   input  qgf_pkg::corners_type      corners,
   qgf_req_if.sink                   req,
   input  qgf_pkg::queue_status_type q_status,
   output logic                      push,
   output qgf_pkg::item_type         push_item
);
   import qgf_pkg::*;

   function automatic logic [LonW-1:0] wrap_lon(input lon_type v);
      logic signed [DiffW-1:0] w;
      w = {v[LonW-1], v};
      if (v[LonW-1]) begin
         w = w + FullTurn;
      end
      return w[LonW-1:0];
   endfunction

   function automatic edge_type classify_edge(
      input lat_type p_lat, input lon_type p_lon,
      input lat_type a_lat_raw, input lon_type a_lon_raw,
      input lat_type b_lat_raw, input lon_type b_lon_raw);
      logic signed [LatW:0]    a_lat;
      logic signed [LatW:0]    b_lat;
      logic signed [LatW:0]    pt_lat;
      logic [LonW-1:0]         a_lon;
      logic [LonW-1:0]         b_lon;
      logic [LonW-1:0]         pt_lon;
      logic [LonW-1:0]         lo;
      logic [LonW-1:0]         hi;
      logic signed [DiffW-1:0] dy_s;
      logic signed [DiffW-1:0] dx_s;
      logic signed [DiffW-1:0] ey_s;
      logic signed [DiffW-1:0] ex_s;
      edge_type                e;
      e = '0;
      // southern endpoint first
      if ($signed(a_lat_raw) > $signed(b_lat_raw)) begin
         a_lat = {b_lat_raw[LatW-1], b_lat_raw};
         b_lat = {a_lat_raw[LatW-1], a_lat_raw};
         a_lon = wrap_lon(b_lon_raw);
         b_lon = wrap_lon(a_lon_raw);
      end else begin
         a_lat = {a_lat_raw[LatW-1], a_lat_raw};
         b_lat = {b_lat_raw[LatW-1], b_lat_raw};
         a_lon = wrap_lon(a_lon_raw);
         b_lon = wrap_lon(b_lon_raw);
      end
      pt_lon = wrap_lon(p_lon);
      pt_lat = {p_lat[LatW-1], p_lat};
      if (pt_lat == a_lat || pt_lat == b_lat) begin
         pt_lat = pt_lat + 32'sd1;
      end
      hi = (a_lon > b_lon) ? a_lon : b_lon;
      lo = (a_lon < b_lon) ? a_lon : b_lon;
      dy_s = {b_lat[LatW], b_lat} - {a_lat[LatW], a_lat};
      dx_s = $signed({1'b0, b_lon}) - $signed({1'b0, a_lon});
      ey_s = {pt_lat[LatW], pt_lat} - {a_lat[LatW], a_lat};
      ex_s = $signed({1'b0, pt_lon}) - $signed({1'b0, a_lon});
      if (dx_s < 0) begin
         dx_s = -dx_s;
         dy_s = -dy_s;
      end
      if (ex_s < 0) begin
         ex_s = -ex_s;
         ey_s = -ey_s;
      end
      priority if (pt_lat > b_lat || pt_lat < a_lat || pt_lon > hi) begin
         e.decided = 1'b1;
         e.crossed = 1'b0;
      end else if (pt_lon < lo) begin
         e.decided = 1'b1;
         e.crossed = 1'b1;
      end else if (a_lon == b_lon || pt_lon == a_lon) begin
         // infinite slope on one side
         e.decided = 1'b1;
         e.crossed = 1'b1;
      end else begin
         e.dy = dy_s;
         e.dx = dx_s[LonW-1:0];
         e.ey = ey_s;
         e.ex = ex_s[LonW-1:0];
      end
      return e;
   endfunction

   assign req.ready = ~q_status.full;
   assign push      = req.valid & req.ready;

   always_comb begin
      for (int k = 0; k < Corners; k++) begin
         push_item.edges[k] = classify_edge(req.point_lat, req.point_lon,
            corners.lat[k], corners.lon[k],
            corners.lat[(k + 1) % Corners], corners.lon[(k + 1) % Corners]);
      end
   end

endmodule

/* design/qgf_fifo.sv */
// Short queue between the front end and the back end.
module qgf_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  qgf_pkg::item_type         push_item,
   input  logic                      pop,
   output qgf_pkg::item_type         pop_item,
   output qgf_pkg::queue_status_type status
);
   import qgf_pkg::*;

   item_type               mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff;
   logic [QueuePtrW-1:0]   wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueuePtrW-1:0]   rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff;
   logic [QueueCntW-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/qgf_back.sv */
// Back end: slope cross-products, crossing count and result register.
module qgf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  qgf_pkg::queue_status_type q_status,
   input  qgf_pkg::item_type         pop_item,
   output logic                      pop,
   qgf_rsp_if.source                 rsp
);
   import qgf_pkg::*;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [Corners-1:0]      s1_decided_ff;
   logic [Corners-1:0]      s1_crossed_ff;
   logic signed [ProdW-1:0] s1_lhs_ff [Corners];
   logic signed [ProdW-1:0] s1_rhs_ff [Corners];
   logic signed [ProdW-1:0] lhs_in [Corners];
   logic signed [ProdW-1:0] rhs_in [Corners];
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    out_inside_ff;
   logic [CountW-1:0]       out_count_ff;
   logic [CountW-1:0]       count_in;
   logic                    s1_load;
   logic                    out_load;

   assign out_load = s1_valid_ff & (~out_valid_ff | rsp.ready);
   assign s1_load  = ~q_status.empty & (~s1_valid_ff | out_load);
   assign pop      = s1_load;

   // ey * dx against dy * ex, both denominators positive
   always_comb begin
      for (int k = 0; k < Corners; k++) begin
         lhs_in[k] = $signed({{(ProdW-DiffW){pop_item.edges[k].ey[DiffW-1]}},
                              pop_item.edges[k].ey})
                   * $signed({{(ProdW-LonW){1'b0}}, pop_item.edges[k].dx});
         rhs_in[k] = $signed({{(ProdW-DiffW){pop_item.edges[k].dy[DiffW-1]}},
                              pop_item.edges[k].dy})
                   * $signed({{(ProdW-LonW){1'b0}}, pop_item.edges[k].ex});
      end
   end

   always_comb begin
      count_in = '0;
      for (int k = 0; k < Corners; k++) begin
         if (s1_decided_ff[k] ? s1_crossed_ff[k] : (s1_lhs_ff[k] >= s1_rhs_ff[k])) begin
            count_in = count_in + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_load | (s1_valid_ff & ~out_load);
      out_valid_in = out_load | (out_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         for (int k = 0; k < Corners; k++) begin
            s1_decided_ff[k] <= pop_item.edges[k].decided;
            s1_crossed_ff[k] <= pop_item.edges[k].crossed;
            s1_lhs_ff[k]     <= lhs_in[k];
            s1_rhs_ff[k]     <= rhs_in[k];
         end
      end
      if (out_load) begin
         out_count_ff  <= count_in;
         out_inside_ff <= count_in[0];
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.inside_res     = out_inside_ff;
   assign rsp.crossing_count = out_count_ff;

endmodule

/* design/quad_geofence_point_in_polygon_top.sv */
// A word accepted on req goes through the queue, the multiply stage and the result
// register before it shows on rsp. Throughput: one word per cycle unless rsp stalls;
// the front end, the four-deep queue and the two-stage back end (multiply, then
// compare and count) each stall alone. Reset: synchronous, active high; clears the
// corner registers to zero and empties the queue and both back-end stages.
`include "quad_geofence_point_in_polygon_top_defines.svh"
module quad_geofence_point_in_polygon_top (
   input  logic                      clock,
   input  logic                      reset,
   qgf_req_if.sink                   req_port,
   qgf_rsp_if.source                 rsp_port,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [qgf_pkg::AddrW-1:0] paddr,
   input  logic [qgf_pkg::DataW-1:0] pwdata,
   output logic [qgf_pkg::DataW-1:0] prdata,
   output logic                      pready
);
   import qgf_pkg::*;

   corners_type      corners;
   queue_status_type q_status;
   item_type         push_item;
   item_type         pop_item;
   logic             push;
   logic             pop;

   qgf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .corners (corners)
   );

   qgf_front u_front (
      .corners   (corners),
      .req       (req_port),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   qgf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   qgf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp      (rsp_port)
   );

   `QGF_ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty)
   `QGF_ASSERT_IMPLY(a_parity, clock, reset, rsp_port.valid, rsp_port.inside_res == rsp_port.crossing_count[0])
   `QGF_ASSERT_IMPLY(a_count_max, clock, reset, rsp_port.valid, rsp_port.crossing_count <= 3'd4)

endmodule
